// ===== rtl/rds_pkg.sv =====
// rds_pkg: shared types and constants of the RSSI diversity selector.
// No dependencies; used by the interfaces, the lanes, the merge stage and the top level.
package rds_pkg;

  localparam int LEVEL_W    = 7;
  localparam int LIMIT_W    = 10;
  localparam int MODE_W     = 2;
  localparam int THRESH_W   = 7;
  localparam int TICKS_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [LEVEL_W-1:0] PERCENT_FULL = LEVEL_W'(100);

  // Divider iterations: the quotient is below 100 once the full-scale case is split off.
  localparam int DIV_STEPS  = LEVEL_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_A,
    REG_MAX_A,
    REG_MIN_B,
    REG_MAX_B,
    REG_MODE,
    REG_THRESH,
    REG_HYST,
    REG_SETTLE
  } cfg_reg_t;

  localparam logic [MODE_W-1:0] MODE_AUTO    = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_FORCE_A = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_FORCE_B = MODE_W'(2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_FINISH
  } sel_state_t;

  typedef enum logic [1:0] {
    KIND_DIV,
    KIND_ZERO,
    KIND_FULL
  } lane_kind_t;

  typedef struct packed {
    logic next_active;
    logic next_target;
    logic hyst_clear;
  } decide_t;

endpackage

// ===== rtl/rds_if.sv =====
// rds_if: valid/ready channels for tick items and result items.
// Depends on rds_pkg for the level width.
interface rds_in_if import rds_pkg::*; #(parameter int ADC_BITS = 10);
  logic                valid;
  logic                ready;
  logic                retune;
  logic [ADC_BITS-1:0] raw_a;
  logic [ADC_BITS-1:0] raw_b;

  modport source(output valid, retune, raw_a, raw_b, input ready);
  modport sink(input valid, retune, raw_a, raw_b, output ready);
endinterface

interface rds_out_if import rds_pkg::*;;
  logic               valid;
  logic               ready;
  logic               measured;
  logic [LEVEL_W-1:0] level_a;
  logic [LEVEL_W-1:0] level_b;
  logic               selected;

  modport source(output valid, measured, level_a, level_b, selected, input ready);
  modport sink(input valid, measured, level_a, level_b, selected, output ready);
endinterface

// ===== rtl/rds_lane.sv =====
// rds_lane: scales one raw sample to 0..100 percent with a restoring divider.
// Depends on rds_pkg. Each conversion is a load step followed by DIV_STEPS divider iterations.
module rds_lane import rds_pkg::*; #(
  parameter int ADC_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [ADC_BITS-1:0] raw,
  input  logic [ADC_BITS-1:0] lo,
  input  logic [ADC_BITS-1:0] hi,
  output logic                done,
  output logic [LEVEL_W-1:0]  level
);

  localparam int NUM_W = ADC_BITS + LEVEL_W;

  logic [ADC_BITS-1:0] n;
  logic [ADC_BITS-1:0] d;
  lane_kind_t          kind_in;
  logic [NUM_W-1:0]    n_ext;
  logic [NUM_W-1:0]    trial;

  logic [NUM_W-1:0]    rem;
  logic [ADC_BITS-1:0] den;
  logic [LEVEL_W-1:0]  quo;
  logic [STEP_W-1:0]   step;
  lane_kind_t          kind;
  logic                busy;

  // Reversed limits use the mirrored magnitudes; a wrong-side sample clamps to zero.
  always_comb begin
    n       = '0;
    d       = '0;
    kind_in = KIND_ZERO;
    if (hi > lo) begin
      n = raw - lo;
      d = hi - lo;
      if (raw > lo) begin
        kind_in = (n >= d) ? KIND_FULL : KIND_DIV;
      end
    end else if (hi < lo) begin
      n = lo - raw;
      d = lo - hi;
      if (raw < lo) begin
        kind_in = (n >= d) ? KIND_FULL : KIND_DIV;
      end
    end
  end

  assign n_ext = NUM_W'(n);
  assign trial = NUM_W'(den) << step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= (n_ext << 6) + (n_ext << 5) + (n_ext << 2);
      den  <= d;
      quo  <= '0;
      step <= STEP_W'(DIV_STEPS - 1);
      kind <= kind_in;
    end else if (busy) begin
      if (rem >= trial) begin
        rem       <= rem - trial;
        quo[step] <= 1'b1;
      end
      step <= step - STEP_W'(1);
    end
  end

  always_comb begin
    case (kind)
      KIND_FULL: level = PERCENT_FULL;
      KIND_DIV:  level = quo;
      default:   level = '0;
    endcase
  end

endmodule

// ===== rtl/rds_merge.sv =====
// rds_merge: combines the two lane levels into the receiver decision.
// Depends on rds_pkg for mode codes and the decide_t result.
module rds_merge import rds_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic [LEVEL_W-1:0]    level_a,
  input  logic [LEVEL_W-1:0]    level_b,
  input  logic [MODE_W-1:0]     mode,
  input  logic [THRESH_W-1:0]   threshold,
  input  logic [TICKS_W-1:0]    hyst_ticks,
  input  logic [COUNT_BITS-1:0] hyst_count,
  input  logic                  active,
  input  logic                  target,
  output decide_t               dec
);

  localparam int CMP_W = (COUNT_BITS > TICKS_W) ? COUNT_BITS : TICKS_W;

  logic               a_gt;
  logic               b_gt;
  logic [LEVEL_W-1:0] mag;
  logic               best;
  logic               elapsed;

  assign a_gt    = level_a > level_b;
  assign b_gt    = level_b > level_a;
  assign mag     = a_gt ? (level_a - level_b) : (level_b - level_a);
  assign best    = a_gt ? 1'b0 : (b_gt ? 1'b1 : active);
  assign elapsed = CMP_W'(hyst_count) >= CMP_W'(hyst_ticks);

  always_comb begin
    dec.next_active = active;
    dec.next_target = target;
    dec.hyst_clear  = 1'b0;
    case (mode)
      MODE_AUTO: begin
        if (mag >= threshold) begin
          if (best == target) begin
            if (elapsed) dec.next_active = target;
          end else begin
            dec.next_target = best;
            dec.hyst_clear  = 1'b1;
          end
        end else begin
          dec.hyst_clear = 1'b1;
        end
      end
      MODE_FORCE_A: dec.next_active = 1'b0;
      MODE_FORCE_B: dec.next_active = 1'b1;
      default:      dec.next_active = active;
    endcase
  end

endmodule

// ===== rtl/rssi_diversity_selector_unit.sv =====
// RSSI diversity selector, top level: tick counters, control sequencer,
// two scaling lanes (rds_lane), decision merge (rds_merge), result register.
//
// Use: each item on in_ch is one tick with a retune flag and raw samples of
// receivers A and B. Every item yields exactly one item on out_ch: measured
// flag, last scaled levels and the active receiver after the tick.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the
// user must do so only while the block is idle, which the block does not enforce.
// Sequence: a tick that is not measured goes from ST_IDLE to ST_FINISH, where
// it is loaded into the result register once that is free. A measured tick runs
// both lanes side by side, one load step and 7 restoring-divider iterations, in
// ST_SCALE, then commits and goes to ST_FINISH. A new tick is taken only in
// ST_IDLE, after the last one has been loaded into the result register.
// Reset (rst, synchronous) restores the configuration, state and control registers
// to their defaults, receiver A active, counters and levels zero.
// A stalled receiver holds the result register; the block still accepts the
// next tick and works on it, then waits to hand its result over.
module rssi_diversity_selector_unit import rds_pkg::*; #(
  parameter int ADC_BITS   = 10,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rds_in_if.sink                in_ch,
  rds_out_if.source             out_ch
);

  localparam int CMP_W = (COUNT_BITS > TICKS_W) ? COUNT_BITS : TICKS_W;

  logic [LIMIT_W-1:0]    min_level_a;
  logic [LIMIT_W-1:0]    max_level_a;
  logic [LIMIT_W-1:0]    min_level_b;
  logic [LIMIT_W-1:0]    max_level_b;
  logic [MODE_W-1:0]     select_mode;
  logic [THRESH_W-1:0]   switch_threshold;
  logic [TICKS_W-1:0]    hysteresis_ticks;
  logic [TICKS_W-1:0]    settle_ticks;

  sel_state_t            state;
  sel_state_t            state_next;
  logic [COUNT_BITS-1:0] settle_count;
  logic [COUNT_BITS-1:0] settle_next;
  logic [COUNT_BITS-1:0] hyst_count;
  logic [COUNT_BITS-1:0] hyst_next;
  logic                  measured_next;
  logic                  measured;
  logic                  active;
  logic                  target;
  logic [LEVEL_W-1:0]    last_level_a;
  logic [LEVEL_W-1:0]    last_level_b;

  logic                  out_valid;
  logic                  out_measured;
  logic [LEVEL_W-1:0]    out_level_a;
  logic [LEVEL_W-1:0]    out_level_b;
  logic                  out_selected;

  logic                  accept;
  logic                  lane_start;
  logic                  commit;
  logic                  out_load;
  logic                  lane_a_done;
  logic                  lane_b_done;
  logic [LEVEL_W-1:0]    lane_a_level;
  logic [LEVEL_W-1:0]    lane_b_level;
  decide_t               dec;

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      min_level_a      <= LIMIT_W'(0);
      max_level_a      <= LIMIT_W'(1023);
      min_level_b      <= LIMIT_W'(0);
      max_level_b      <= LIMIT_W'(1023);
      select_mode      <= MODE_AUTO;
      switch_threshold <= THRESH_W'(5);
      hysteresis_ticks <= TICKS_W'(5);
      settle_ticks     <= TICKS_W'(25);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_A:  min_level_a      <= cfg_data[LIMIT_W-1:0];
        REG_MAX_A:  max_level_a      <= cfg_data[LIMIT_W-1:0];
        REG_MIN_B:  min_level_b      <= cfg_data[LIMIT_W-1:0];
        REG_MAX_B:  max_level_b      <= cfg_data[LIMIT_W-1:0];
        REG_MODE:   select_mode      <= cfg_data[MODE_W-1:0];
        REG_THRESH: switch_threshold <= cfg_data[THRESH_W-1:0];
        REG_HYST:   hysteresis_ticks <= cfg_data[TICKS_W-1:0];
        REG_SETTLE: settle_ticks     <= cfg_data[TICKS_W-1:0];
        default:    ;
      endcase
    end
  end

  // Saturating tick counters
  always_comb begin
    if (in_ch.retune) settle_next = '0;
    else if (&settle_count) settle_next = settle_count;
    else settle_next = settle_count + COUNT_BITS'(1);
    hyst_next     = (&hyst_count) ? hyst_count : hyst_count + COUNT_BITS'(1);
    measured_next = CMP_W'(settle_next) >= CMP_W'(settle_ticks);
  end

  assign accept = in_ch.valid && in_ch.ready;

  rds_lane #(.ADC_BITS(ADC_BITS)) u_lane_a (
    .clk   (clk),
    .rst   (rst),
    .start (lane_start),
    .raw   (in_ch.raw_a),
    .lo    (ADC_BITS'(min_level_a)),
    .hi    (ADC_BITS'(max_level_a)),
    .done  (lane_a_done),
    .level (lane_a_level)
  );

  rds_lane #(.ADC_BITS(ADC_BITS)) u_lane_b (
    .clk   (clk),
    .rst   (rst),
    .start (lane_start),
    .raw   (in_ch.raw_b),
    .lo    (ADC_BITS'(min_level_b)),
    .hi    (ADC_BITS'(max_level_b)),
    .done  (lane_b_done),
    .level (lane_b_level)
  );

  rds_merge #(.COUNT_BITS(COUNT_BITS)) u_merge (
    .level_a    (lane_a_level),
    .level_b    (lane_b_level),
    .mode       (select_mode),
    .threshold  (switch_threshold),
    .hyst_ticks (hysteresis_ticks),
    .hyst_count (hyst_count),
    .active     (active),
    .target     (target),
    .dec        (dec)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next  = state;
    in_ch.ready = 1'b0;
    lane_start  = 1'b0;
    commit      = 1'b0;
    out_load    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          lane_start = measured_next;
          state_next = measured_next ? ST_SCALE : ST_FINISH;
        end
      end
      ST_SCALE: begin
        if (lane_a_done && lane_b_done) begin
          commit     = 1'b1;
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ch.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Tick state
  always_ff @(posedge clk) begin
    if (rst) begin
      settle_count <= '0;
      hyst_count   <= '0;
      measured     <= 1'b0;
      active       <= 1'b0;
      target       <= 1'b0;
      last_level_a <= '0;
      last_level_b <= '0;
    end else if (accept) begin
      settle_count <= settle_next;
      hyst_count   <= hyst_next;
      measured     <= measured_next;
    end else if (commit) begin
      last_level_a <= lane_a_level;
      last_level_b <= lane_b_level;
      active       <= dec.next_active;
      target       <= dec.next_target;
      if (dec.hyst_clear) hyst_count <= '0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_measured <= measured;
      out_level_a  <= last_level_a;
      out_level_b  <= last_level_b;
      out_selected <= active;
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.measured = out_measured;
  assign out_ch.level_a  = out_level_a;
  assign out_ch.level_b  = out_level_b;
  assign out_ch.selected = out_selected;

  // Checks
  a_lanes_in_step: assert property (@(posedge clk) disable iff (rst)
    lane_a_done == lane_b_done)
    else $error("scaling lanes finished out of step");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ch.ready)
    else $error("new item taken while one is in work");

  a_levels_in_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.level_a <= PERCENT_FULL && out_ch.level_b <= PERCENT_FULL))
    else $error("level above full scale");

  a_force_b: assert property (@(posedge clk) disable iff (rst)
    (commit && select_mode == MODE_FORCE_B) |=> active)
    else $error("forced receiver B not selected");

endmodule

// ===== test/tb_rssi_diversity_selector_unit.sv =====
// Testbench for rssi_diversity_selector_unit: random and directed tick items,
// checked against an in-bench model of scaling, settling and hysteresis switching.
// Depends on rds_pkg and the rds_in_if / rds_out_if interfaces.
`timescale 1ns / 1ps

module tb_rssi_diversity_selector_unit;
  import rds_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = MODE_W'(3);
  localparam logic RX_A = 1'b0;
  localparam logic RX_B = 1'b1;
  localparam int   RESULT_PAUSE = 12;

  typedef struct packed {
    logic               retune;
    logic [LIMIT_W-1:0] raw_a;
    logic [LIMIT_W-1:0] raw_b;
  } tick_t;

  typedef struct packed {
    logic               measured;
    logic [LEVEL_W-1:0] level_a;
    logic [LEVEL_W-1:0] level_b;
    logic               selected;
  } verdict_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rds_in_if #(.ADC_BITS(LIMIT_W)) in_ch ();
  rds_out_if                      out_ch ();

  rssi_diversity_selector_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // model configuration
  logic [LIMIT_W-1:0]  lim_min_a, lim_max_a, lim_min_b, lim_max_b;
  logic [MODE_W-1:0]   sel_mode;
  logic [THRESH_W-1:0] sw_thresh;
  logic [TICKS_W-1:0]  hyst_ticks, settle_ticks;

  // model state
  logic               act_rx, tgt_rx;
  logic [TICKS_W-1:0] hyst_cnt, settle_cnt;
  logic [LEVEL_W-1:0] lvl_a, lvl_b;

  tick_t    pending_ticks[$];
  verdict_t expected_verdicts[$];
  int       n_mismatch;

  bit no_idle;
  int in_gap_pct, out_stall_pct;
  int in_gap, out_stall;
  tick_t held_tick;

  function automatic logic [LEVEL_W-1:0] percent_level(logic [LIMIT_W-1:0] raw,
                                                       logic [LIMIT_W-1:0] lo,
                                                       logic [LIMIT_W-1:0] hi);
    int x, a, b, v;
    x = raw;
    a = lo;
    b = hi;
    if (a == b) return '0;
    v = ((x - a) * 100) / (b - a);  // int division truncates toward zero
    if (v < 0) v = 0;
    if (v > 100) v = 100;
    return LEVEL_W'(v);
  endfunction

  function automatic void apply_config(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_MIN_A:  lim_min_a    = data[LIMIT_W-1:0];
      REG_MAX_A:  lim_max_a    = data[LIMIT_W-1:0];
      REG_MIN_B:  lim_min_b    = data[LIMIT_W-1:0];
      REG_MAX_B:  lim_max_b    = data[LIMIT_W-1:0];
      REG_MODE:   sel_mode     = data[MODE_W-1:0];
      REG_THRESH: sw_thresh    = data[THRESH_W-1:0];
      REG_HYST:   hyst_ticks   = data[TICKS_W-1:0];
      REG_SETTLE: settle_ticks = data[TICKS_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void predict_tick(tick_t t);
    verdict_t v;
    int       diff, mag;
    logic     best, nxt;
    if (t.retune) settle_cnt = '0;
    else if (settle_cnt != '1) settle_cnt = settle_cnt + 1'b1;
    if (hyst_cnt != '1) hyst_cnt = hyst_cnt + 1'b1;
    v.measured = (settle_cnt >= settle_ticks);
    if (v.measured) begin
      lvl_a = percent_level(t.raw_a, lim_min_a, lim_max_a);
      lvl_b = percent_level(t.raw_b, lim_min_b, lim_max_b);
      nxt = act_rx;
      case (sel_mode)
        MODE_AUTO: begin
          diff = int'(lvl_a) - int'(lvl_b);
          mag  = (diff < 0) ? -diff : diff;
          best = (diff > 0) ? RX_A : ((diff < 0) ? RX_B : act_rx);
          if (mag >= int'(sw_thresh)) begin
            if (best == tgt_rx) begin
              if (hyst_cnt >= hyst_ticks) nxt = tgt_rx;
            end else begin
              tgt_rx   = best;
              hyst_cnt = '0;
            end
          end else begin
            hyst_cnt = '0;
          end
        end
        MODE_FORCE_A: nxt = RX_A;
        MODE_FORCE_B: nxt = RX_B;
        default: ;  // unused mode holds everything
      endcase
      act_rx = nxt;
    end
    v.level_a  = lvl_a;
    v.level_b  = lvl_b;
    v.selected = act_rx;
    expected_verdicts.push_back(v);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("rssi_diversity_selector_unit test failed");
    $finish;
  end

  // tick driver
  always @(posedge clk) begin : tick_drive
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_gap      <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_tick(held_tick);
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap      <= in_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          held_tick    = pending_ticks.pop_front();
          in_ch.retune <= held_tick.retune;
          in_ch.raw_a  <= held_tick.raw_a;
          in_ch.raw_b  <= held_tick.raw_b;
          in_ch.valid  <= 1'b1;
          if (!no_idle && $urandom_range(99) < in_gap_pct) in_gap <= $urandom_range(19, 1);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : result_check
    verdict_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_stall    <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_verdicts.size() == 0) begin
          n_mismatch = n_mismatch + 1;
          if (n_mismatch <= 10)
            $display("unexpected result item: measured=%0d level_a=%0d level_b=%0d sel=%0d",
                     out_ch.measured, out_ch.level_a, out_ch.level_b, out_ch.selected);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_ch.measured !== want.measured || out_ch.level_a !== want.level_a ||
              out_ch.level_b !== want.level_b || out_ch.selected !== want.selected) begin
            n_mismatch = n_mismatch + 1;
            if (n_mismatch <= 10)
              $display("mismatch at %0t: want m=%0d a=%0d b=%0d sel=%0d,",
                       $realtime, want.measured, want.level_a, want.level_b, want.selected,
                       " got m=%0d a=%0d b=%0d sel=%0d",
                       out_ch.measured, out_ch.level_a, out_ch.level_b, out_ch.selected);
          end
        end
      end
      if (out_stall > 0) begin
        out_stall    <= out_stall - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!no_idle && $urandom_range(99) < out_stall_pct) out_stall <= $urandom_range(19, 1);
      end
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
    logic [CFG_DATA_W-1:0] data;
    int w;
    case (idx)
      REG_MODE:            w = MODE_W;
      REG_THRESH:          w = THRESH_W;
      REG_HYST, REG_SETTLE: w = TICKS_W;
      default:             w = LIMIT_W;
    endcase
    data = CFG_DATA_W'(value);
    // junk above the register width must be dropped
    if (w < CFG_DATA_W && $urandom_range(3) == 0) data = data | (CFG_DATA_W'($urandom) << w);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    apply_config(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_ticks.size() > 0 || in_ch.valid || expected_verdicts.size() > 0)
      @(negedge clk);
    repeat (RESULT_PAUSE) @(posedge clk);
  endtask

  task automatic push_tick(input logic rt, input int unsigned a, input int unsigned b);
    tick_t t;
    t.retune = rt;
    t.raw_a  = LIMIT_W'(a);
    t.raw_b  = LIMIT_W'(b);
    pending_ticks.push_back(t);
  endtask

  function automatic logic [LIMIT_W-1:0] next_raw(logic [LIMIT_W-1:0] prev,
                                                  logic [LIMIT_W-1:0] lo,
                                                  logic [LIMIT_W-1:0] hi);
    int r, v;
    r = $urandom_range(99);
    if (r < 15) return $urandom_range(1) ? '1 : '0;
    if (r < 55) begin
      // jitter keeps levels steady long enough for the hysteresis to run out
      v = int'(prev) + int'($urandom_range(6)) - 3;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return LIMIT_W'(v);
    end
    if (r < 75) return LIMIT_W'($urandom);
    return LIMIT_W'($urandom_range(int'(lo), int'(hi)));
  endfunction

  task automatic queue_random_ticks(input int n, input int retune_pct,
                                    inout logic [LIMIT_W-1:0] pa, inout logic [LIMIT_W-1:0] pb);
    tick_t t;
    repeat (n) begin
      t.retune = ($urandom_range(99) < retune_pct);
      t.raw_a  = next_raw(pa, lim_min_a, lim_max_a);
      t.raw_b  = next_raw(pb, lim_min_b, lim_max_b);
      pa = t.raw_a;
      pb = t.raw_b;
      pending_ticks.push_back(t);
    end
  endtask

  task automatic pick_limits(input cfg_reg_t lo_reg, input cfg_reg_t hi_reg);
    int r, lo, hi;
    r = $urandom_range(9);
    case (r)
      6: begin lo = 0; hi = 1023; end
      7: begin lo = $urandom_range(1023); hi = lo; end
      8: begin hi = $urandom_range(0, 500); lo = $urandom_range(501, 1023); end
      9: begin lo = $urandom_range(1023); hi = $urandom_range(1023); end
      default: begin lo = $urandom_range(0, 300); hi = $urandom_range(600, 1023); end
    endcase
    write_reg(lo_reg, lo);
    write_reg(hi_reg, hi);
  endtask

  task automatic pick_config();
    int r;
    pick_limits(REG_MIN_A, REG_MAX_A);
    pick_limits(REG_MIN_B, REG_MAX_B);
    r = $urandom_range(9);
    write_reg(REG_MODE, (r < 6) ? MODE_AUTO : $urandom_range(3, 1));
    r = $urandom_range(9);
    case (r)
      0: write_reg(REG_THRESH, 0);
      1: write_reg(REG_THRESH, 100);
      2: write_reg(REG_THRESH, $urandom_range(127, 101));
      default: write_reg(REG_THRESH, $urandom_range(30));
    endcase
    r = $urandom_range(9);
    case (r)
      0: write_reg(REG_HYST, 0);
      1: write_reg(REG_HYST, 65535);
      default: write_reg(REG_HYST, $urandom_range(8));
    endcase
    r = $urandom_range(11);
    case (r)
      0: write_reg(REG_SETTLE, 0);
      1: write_reg(REG_SETTLE, 65535);
      default: write_reg(REG_SETTLE, $urandom_range(6));
    endcase
  endtask

  initial begin : stimulus
    logic [LIMIT_W-1:0] pa, pb;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_ch.valid  = 1'b0;
    in_ch.retune = 1'b0;
    in_ch.raw_a  = '0;
    in_ch.raw_b  = '0;
    out_ch.ready = 1'b0;
    lim_min_a = '0;
    lim_max_a = 10'd1023;
    lim_min_b = '0;
    lim_max_b = 10'd1023;
    sel_mode     = MODE_AUTO;
    sw_thresh    = 7'd5;
    hyst_ticks   = 16'd5;
    settle_ticks = 16'd25;
    act_rx     = RX_A;
    tgt_rx     = RX_A;
    hyst_cnt   = '0;
    settle_cnt = '0;
    lvl_a      = '0;
    lvl_b      = '0;
    n_mismatch = 0;
    no_idle    = 1'b0;
    in_gap_pct    = 20;
    out_stall_pct = 20;
    pa = '0;
    pb = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: still settling, nothing measured
    push_tick(1'b1, 1023, 0);
    push_tick(1'b0, 0, 1023);
    push_tick(1'b0, 512, 512);
    wait_idle();

    // auto mode: hold-off, target change, tie, small difference, retune with no settle time
    write_reg(REG_SETTLE, 0);
    write_reg(REG_HYST, 2);
    write_reg(REG_THRESH, 5);
    push_tick(1'b0, 1023, 0);
    push_tick(1'b0, 0, 1023);
    push_tick(1'b0, 0, 1023);
    push_tick(1'b0, 0, 1023);
    push_tick(1'b0, 512, 512);
    push_tick(1'b0, 520, 500);
    push_tick(1'b1, 1023, 1023);
    push_tick(1'b0, 1023, 0);
    push_tick(1'b0, 1023, 0);
    push_tick(1'b0, 1023, 0);
    wait_idle();

    // equal limits on A, reversed limits on B, unused mode
    write_reg(REG_MIN_A, 512);
    write_reg(REG_MAX_A, 512);
    write_reg(REG_MIN_B, 1000);
    write_reg(REG_MAX_B, 100);
    write_reg(REG_MODE, MODE_UNUSED);
    push_tick(1'b0, 700, 50);
    push_tick(1'b0, 300, 600);
    push_tick(1'b0, 1023, 1023);
    wait_idle();

    // forced modes
    write_reg(REG_MODE, MODE_FORCE_B);
    push_tick(1'b0, 0, 0);
    push_tick(1'b0, 1023, 1023);
    wait_idle();
    write_reg(REG_MODE, MODE_FORCE_A);
    push_tick(1'b0, 1023, 0);
    push_tick(1'b1, 0, 1023);
    wait_idle();

    // random phases
    repeat (12) begin
      pick_config();
      case ($urandom_range(3))
        0: in_gap_pct = 0;
        1: in_gap_pct = 5;
        2: in_gap_pct = 20;
        default: in_gap_pct = 50;
      endcase
      case ($urandom_range(3))
        0: out_stall_pct = 0;
        1: out_stall_pct = 5;
        2: out_stall_pct = 20;
        default: out_stall_pct = 50;
      endcase
      queue_random_ticks($urandom_range(55, 30), $urandom_range(10, 1), pa, pb);
      wait_idle();
    end

    // steady stretch without retune, no idling from here on
    no_idle = 1'b1;
    write_reg(REG_MIN_A, 0);
    write_reg(REG_MAX_A, 1023);
    write_reg(REG_MIN_B, 0);
    write_reg(REG_MAX_B, 1023);
    write_reg(REG_MODE, MODE_FORCE_B);
    write_reg(REG_SETTLE, 20);
    write_reg(REG_HYST, 10);
    write_reg(REG_THRESH, 0);
    queue_random_ticks(60, 0, pa, pb);
    wait_idle();
    write_reg(REG_MODE, MODE_AUTO);
    queue_random_ticks(40, 0, pa, pb);
    wait_idle();

    if (n_mismatch == 0 && expected_verdicts.size() == 0) begin
      $display("rssi_diversity_selector_unit test passed");
    end else begin
      $display("rssi_diversity_selector_unit test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rds_pkg.sv
rtl/rds_if.sv
rtl/rds_lane.sv
rtl/rds_merge.sv
rtl/rssi_diversity_selector_unit.sv
test/tb_rssi_diversity_selector_unit.sv
